// File: sv/fqd_pkg.sv
// Package for the FIFO queue with membership search.
// Holds the command and status codes, the controller states and the cell control struct.
// Depends on nothing.
`default_nettype none

package fqd_pkg;

	localparam int ID_W     = 16;
	localparam int CMD_W    = 3;
	localparam int AMT_W    = 8;
	localparam int SIZE_W   = 5;
	localparam int STATUS_W = 2;
	localparam int IN_W     = 32;
	localparam int OUT_W    = 24;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH        = 3'd0,
		CMD_PUSH_UNIQUE = 3'd1,
		CMD_CONTAINS    = 3'd2,
		CMD_POP         = 3'd3,
		CMD_READ_AT     = 3'd4,
		CMD_DROP_N      = 3'd5,
		CMD_CLEAR       = 3'd6,
		CMD_NOP         = 3'd7
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_RANGE = 2'd1,
		STATUS_FULL  = 2'd2,
		STATUS_DUP   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_SHIFT = 2'd1,
		ST_SCAN  = 2'd2
	} state_t;

	// Controls shared by every cell of the chain.
	typedef struct packed {
		logic shift;    // take the entry of the next cell
		logic rd_load;  // copy the entry into the read line
		logic rd_shift; // move the read line one cell toward the head
	} cell_ctrl_t;

endpackage

`default_nettype wire

// File: sv/fqd_cell.sv
// One cell of the queue chain: one stored id, one read-line register and a compare.
// Depends on fqd_pkg.
`default_nettype none

module fqd_cell (
	input  wire logic                    clk,
	input  wire fqd_pkg::cell_ctrl_t     ctrl,
	input  wire logic                    push_here,
	input  wire logic                    live,
	input  wire logic [fqd_pkg::ID_W-1:0] value,
	input  wire logic [fqd_pkg::ID_W-1:0] next_data,
	input  wire logic [fqd_pkg::ID_W-1:0] next_rd,
	output logic      [fqd_pkg::ID_W-1:0] data_q,
	output logic      [fqd_pkg::ID_W-1:0] rd_q,
	output logic                         match
);

	always_ff @(posedge clk) begin
		if (push_here) begin
			data_q <= value;
		end else if (ctrl.shift) begin
			data_q <= next_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.rd_load) begin
			rd_q <= data_q;
		end else if (ctrl.rd_shift) begin
			rd_q <= next_rd;
		end
	end

	assign match = live && (data_q == value);

endmodule

`default_nettype wire

// File: sv/fifo_queue_with_dedup_top.sv
// Top level of the FIFO queue with membership search: controller and chain of cells.
// Depends on fqd_pkg and fqd_cell.
`default_nettype none

// A bounded FIFO of 16-bit ids kept in a chain of DEPTH cells, the head in cell zero.
// Each command transfer gives exactly one result transfer. Push, push_unique, contains,
// pop, clear and a read of position zero or one are answered from the idle state; every
// cell compares its id in parallel for the membership search. An in-range read at position
// p of two or more goes through the scan state, as the entries move one cell per cycle
// along a read line toward the head. A drop of n entries goes through the shift state, as
// the queue shifts one cell per cycle, and hands over its result once no shift is left.
// One command is worked on at a time; a new command is taken in the idle state once the
// previous result has gone or is being taken on the output side.
module fifo_queue_with_dedup_top #(
	parameter int DEPTH = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	// cmd [2:0], value [18:3], amount [26:19], zero fill [31:27]
	input  wire logic [fqd_pkg::IN_W-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	// data [15:0], hit [16], size [21:17], status [23:22]
	output logic      [fqd_pkg::OUT_W-1:0] m_tdata
);

	localparam int CW = $clog2(DEPTH + 1);

	typedef logic [fqd_pkg::ID_W-1:0] id_t;

	fqd_pkg::cmd_t                 cmd;
	id_t                           value;
	logic [fqd_pkg::AMT_W-1:0]     amount;
	logic [fqd_pkg::AMT_W-1:0]     pos;
	logic                          accept;

	fqd_pkg::state_t               state_q, state_d;
	logic [CW-1:0]                 count_q, count_d;
	logic [fqd_pkg::AMT_W-1:0]     rem_q, rem_d;

	fqd_pkg::cell_ctrl_t           ctrl;
	logic                          push_en;
	id_t                           cell_data [DEPTH];
	id_t                           cell_rd   [DEPTH];
	logic [DEPTH-1:0]              match;
	logic                          any_match;
	logic                          full;

	logic                          out_valid_q;
	logic                          out_load;
	id_t                           out_data_q, out_data_d;
	logic                          out_hit_q, out_hit_d;
	logic [fqd_pkg::SIZE_W-1:0]    out_size_q, out_size_d;
	fqd_pkg::status_t              out_status_q, out_status_d;

	assign cmd    = fqd_pkg::cmd_t'(s_tdata[2:0]);
	assign value  = s_tdata[18:3];
	assign amount = s_tdata[26:19];
	assign pos    = (amount == '0) ? fqd_pkg::AMT_W'(1) : amount;

	assign s_tready  = (state_q == fqd_pkg::ST_IDLE) && (!out_valid_q || m_tready);
	assign accept    = s_tvalid && s_tready;
	assign any_match = |match;
	assign full      = (32'(count_q) >= DEPTH);

	// Cell i sits at position i from the head; the last cell takes zeros from beyond.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		id_t  nd, nr;
		logic live;

		if (i == DEPTH - 1) begin : g_end
			assign nd = '0;
			assign nr = '0;
		end else begin : g_mid
			assign nd = cell_data[i+1];
			assign nr = cell_rd[i+1];
		end

		assign live = (CW'(i) < count_q);

		fqd_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.push_here (push_en && (count_q == CW'(i))),
			.live      (live),
			.value     (value),
			.next_data (nd),
			.next_rd   (nr),
			.data_q    (cell_data[i]),
			.rd_q      (cell_rd[i]),
			.match     (match[i])
		);
	end

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		rem_d        = rem_q;
		ctrl         = '0;
		push_en      = 1'b0;
		out_load     = 1'b0;
		out_data_d   = '0;
		out_hit_d    = 1'b0;
		out_size_d   = fqd_pkg::SIZE_W'(count_q);
		out_status_d = fqd_pkg::STATUS_OK;

		case (state_q)
			fqd_pkg::ST_IDLE: begin
				if (accept) begin
					case (cmd)
						fqd_pkg::CMD_PUSH, fqd_pkg::CMD_PUSH_UNIQUE: begin
							out_load = 1'b1;
							if (cmd == fqd_pkg::CMD_PUSH_UNIQUE && any_match) begin
								out_status_d = fqd_pkg::STATUS_DUP;
							end else if (full) begin
								out_status_d = fqd_pkg::STATUS_FULL;
							end else begin
								push_en    = 1'b1;
								count_d    = count_q + CW'(1);
								out_hit_d  = 1'b1;
								out_size_d = fqd_pkg::SIZE_W'(count_d);
							end
						end
						fqd_pkg::CMD_CONTAINS: begin
							out_load  = 1'b1;
							out_hit_d = any_match;
						end
						fqd_pkg::CMD_POP: begin
							out_load = 1'b1;
							if (count_q == '0) begin
								out_status_d = fqd_pkg::STATUS_RANGE;
							end else begin
								ctrl.shift = 1'b1;
								count_d    = count_q - CW'(1);
								out_data_d = cell_data[0];
								out_hit_d  = 1'b1;
								out_size_d = fqd_pkg::SIZE_W'(count_d);
							end
						end
						fqd_pkg::CMD_READ_AT: begin
							if (32'(pos) > 32'(count_q)) begin
								out_load     = 1'b1;
								out_status_d = fqd_pkg::STATUS_RANGE;
							end else if (pos == fqd_pkg::AMT_W'(1)) begin
								out_load   = 1'b1;
								out_data_d = cell_data[0];
								out_hit_d  = 1'b1;
							end else begin
								ctrl.rd_load = 1'b1;
								rem_d        = pos - fqd_pkg::AMT_W'(1);
								state_d      = fqd_pkg::ST_SCAN;
							end
						end
						fqd_pkg::CMD_DROP_N: begin
							if (32'(amount) > 32'(count_q)) begin
								rem_d = fqd_pkg::AMT_W'(count_q);
							end else begin
								rem_d = amount;
							end
							state_d = fqd_pkg::ST_SHIFT;
						end
						fqd_pkg::CMD_CLEAR: begin
							out_load  = 1'b1;
							out_hit_d = 1'b1;
							count_d   = '0;
						end
						default: begin
							out_load = 1'b1;
						end
					endcase
				end
			end
			fqd_pkg::ST_SHIFT: begin
				if (rem_q == '0) begin
					out_load  = 1'b1;
					out_hit_d = 1'b1;
					state_d   = fqd_pkg::ST_IDLE;
				end else begin
					ctrl.shift = 1'b1;
					count_d    = count_q - CW'(1);
					rem_d      = rem_q - fqd_pkg::AMT_W'(1);
				end
			end
			fqd_pkg::ST_SCAN: begin
				if (rem_q == '0) begin
					out_load   = 1'b1;
					out_data_d = cell_rd[0];
					out_hit_d  = 1'b1;
					state_d    = fqd_pkg::ST_IDLE;
				end else begin
					ctrl.rd_shift = 1'b1;
					rem_d         = rem_q - fqd_pkg::AMT_W'(1);
				end
			end
			default: begin
				state_d = fqd_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fqd_pkg::ST_IDLE;
			count_q     <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rem_q   <= rem_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q   <= out_data_d;
			out_hit_q    <= out_hit_d;
			out_size_q   <= out_size_d;
			out_status_q <= out_status_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_status_q, out_size_q, out_hit_q, out_data_q};

endmodule

`default_nettype wire

// File: test/tb_fifo_queue_with_dedup_top.sv
// Testbench for the FIFO queue with membership search, driven through its stream ports.
// A built-in queue predictor checks every result transfer; needs fqd_pkg and the top level.
`timescale 1ns / 100ps

module tb_fifo_queue_with_dedup_top;

	localparam int QDEPTH       = 16;
	localparam int TOTAL_CMDS   = 1050;
	localparam int TAIL_CYCLES  = 300;
	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int POOL_SIZE    = 12;
	// Upper bounds of r in 0..99 for push .. clear; anything above is the idle code.
	localparam int CUTS [3][7] = '{
		'{45, 70, 80, 90, 97, 99, 99},
		'{20, 35, 50, 65, 80, 90, 97},
		'{10, 20, 30, 55, 75, 90, 97}
	};

	typedef struct packed {
		fqd_pkg::status_t            status;
		logic [fqd_pkg::SIZE_W-1:0]  size;
		logic                        hit;
		logic [fqd_pkg::ID_W-1:0]    data;
	} reply_t;

	typedef struct {
		fqd_pkg::cmd_t              cmd;
		logic [fqd_pkg::ID_W-1:0]   id;
		logic [fqd_pkg::AMT_W-1:0]  amount;
		int                         gap;
		bit                         hold;
	} cmd_req_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        s_tvalid = 1'b0;
	logic                        s_tready;
	logic [fqd_pkg::IN_W-1:0]    s_tdata = '0;
	logic                        m_tvalid;
	logic                        m_tready = 1'b0;
	logic [fqd_pkg::OUT_W-1:0]   m_tdata;

	logic              in_taken = 1'b0;
	logic              out_taken = 1'b0;
	int                cycles = 0;
	int                mismatches = 0;
	int                results_checked = 0;
	int                rx_wait = 0;
	int                rx_quiet = 0;

	cmd_req_t          cmds_to_send[$];
	reply_t            replies_due[$];

	// Predicted contents of the queue.
	logic [fqd_pkg::ID_W-1:0]  q_ids [QDEPTH];
	int                q_head = 0;
	int                q_count = 0;
	int                q_peak = 0;

	int                cmds_seen [8];
	int                full_refusals = 0;
	int                dup_refusals = 0;
	int                range_misses = 0;

	fifo_queue_with_dedup_top #(
		.DEPTH(QDEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #2 clk = ~clk;

	function automatic reply_t predict_reply(fqd_pkg::cmd_t cmd,
			logic [fqd_pkg::ID_W-1:0] id, logic [fqd_pkg::AMT_W-1:0] amount);
		reply_t r;
		bit found;
		bit cleared;
		int n;
		int removed;
		r = '{status: fqd_pkg::STATUS_OK, size: '0, hit: 1'b0, data: '0};
		found = 0;
		cleared = 0;
		removed = 0;
		for (int i = 0; i < q_count; i++)
			if (q_ids[(q_head + i) % QDEPTH] == id)
				found = 1;
		case (cmd)
			fqd_pkg::CMD_PUSH, fqd_pkg::CMD_PUSH_UNIQUE: begin
				if (cmd == fqd_pkg::CMD_PUSH_UNIQUE && found)
					r.status = fqd_pkg::STATUS_DUP;
				else if (q_count >= QDEPTH)
					r.status = fqd_pkg::STATUS_FULL;
				else begin
					q_ids[(q_head + q_count) % QDEPTH] = id;
					q_count++;
					r.hit = 1'b1;
				end
			end
			fqd_pkg::CMD_CONTAINS: r.hit = found;
			fqd_pkg::CMD_POP: begin
				if (q_count == 0)
					r.status = fqd_pkg::STATUS_RANGE;
				else begin
					r.data = q_ids[q_head];
					q_head = (q_head + 1) % QDEPTH;
					q_count--;
					r.hit = 1'b1;
				end
			end
			fqd_pkg::CMD_READ_AT: begin
				n = (amount == 0) ? 1 : int'(amount);
				if (n > q_count)
					r.status = fqd_pkg::STATUS_RANGE;
				else begin
					r.data = q_ids[(q_head + n - 1) % QDEPTH];
					r.hit = 1'b1;
				end
			end
			fqd_pkg::CMD_DROP_N: begin
				n = (int'(amount) > q_count) ? q_count : int'(amount);
				q_head = (q_head + n) % QDEPTH;
				q_count -= n;
				r.hit = 1'b1;
			end
			fqd_pkg::CMD_CLEAR: begin
				removed = q_count;
				cleared = 1;
				q_count = 0;
				q_head = 0;
				r.hit = 1'b1;
			end
			default: ;
		endcase
		r.size = fqd_pkg::SIZE_W'(cleared ? removed : q_count);
		if (q_count > q_peak)
			q_peak = q_count;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [fqd_pkg::ID_W-1:0] want,
			logic [fqd_pkg::ID_W-1:0] got);
		mismatches++;
		$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
	endtask

	task automatic queue_cmd(fqd_pkg::cmd_t cmd, logic [fqd_pkg::ID_W-1:0] id,
			logic [fqd_pkg::AMT_W-1:0] amount, int gap, bit hold);
		cmd_req_t req;
		req.cmd = cmd;
		req.id = id;
		req.amount = amount;
		req.gap = gap;
		req.hold = hold;
		cmds_to_send.push_back(req);
	endtask

	// Sender: one command per transfer, after its gap and, if held, after all results.
	always @(negedge clk) begin
		logic                      next_valid;
		logic [fqd_pkg::IN_W-1:0]  next_data;
		cmd_req_t                  req;
		next_valid = s_tvalid;
		next_data = s_tdata;
		if (arst_n) begin
			if (s_tvalid && in_taken)
				next_valid = 1'b0;
			if (!next_valid && cmds_to_send.size() > 0) begin
				if (cmds_to_send[0].gap > 0)
					cmds_to_send[0].gap = cmds_to_send[0].gap - 1;
				else if (!cmds_to_send[0].hold || replies_due.size() == 0) begin
					req = cmds_to_send.pop_front();
					next_valid = 1'b1;
					next_data = {5'b0, req.amount, req.id, req.cmd};
				end
			end
		end
		s_tvalid <= next_valid;
		s_tdata <= next_data;
	end

	// Receiver: after a result transfer it may hold off before taking the next one.
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_taken) begin
				if (rx_quiet > 0) begin
					rx_quiet--;
					rx_wait = 0;
				end else if ($urandom_range(0, 39) == 0) begin
					rx_quiet = $urandom_range(30, 80);
					rx_wait = 0;
				end else
					rx_wait = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 18);
			end
			if (rx_wait > 0) begin
				rx_wait--;
				m_tready <= 1'b0;
			end else
				m_tready <= 1'b1;
		end
	end

	// Checker: a result is compared before a command taken at the same edge is predicted,
	// since that result always belongs to an earlier command.
	always @(posedge clk) begin
		reply_t         got;
		reply_t         want;
		fqd_pkg::cmd_t  cmd;
		in_taken <= s_tvalid && s_tready;
		out_taken <= m_tvalid && m_tready;
		if (arst_n && m_tvalid && m_tready) begin
			got = reply_t'(m_tdata);
			if (replies_due.size() == 0) begin
				mismatches++;
				$display("%0t: result with none outstanding, expected none, actual %h",
					$time, m_tdata);
			end else begin
				want = replies_due.pop_front();
				results_checked++;
				if (got.data !== want.data)
					report_mismatch("data", want.data, got.data);
				if (got.hit !== want.hit)
					report_mismatch("hit", 16'(want.hit), 16'(got.hit));
				if (got.size !== want.size)
					report_mismatch("size", 16'(want.size), 16'(got.size));
				if (got.status !== want.status)
					report_mismatch("status", 16'(want.status), 16'(got.status));
			end
		end
		if (arst_n && s_tvalid && s_tready) begin
			cmd = fqd_pkg::cmd_t'(s_tdata[fqd_pkg::CMD_W-1:0]);
			want = predict_reply(cmd, s_tdata[fqd_pkg::CMD_W +: fqd_pkg::ID_W],
				s_tdata[fqd_pkg::CMD_W + fqd_pkg::ID_W +: fqd_pkg::AMT_W]);
			cmds_seen[int'(cmd)]++;
			if (want.status == fqd_pkg::STATUS_FULL)
				full_refusals++;
			if (want.status == fqd_pkg::STATUS_DUP)
				dup_refusals++;
			if (want.status == fqd_pkg::STATUS_RANGE)
				range_misses++;
			replies_due.push_back(want);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("%0t: run did not finish within %0d cycles", $time, LIMIT_CYCLES);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		logic [fqd_pkg::ID_W-1:0]   pool [POOL_SIZE];
		logic [fqd_pkg::ID_W-1:0]   base;
		logic [fqd_pkg::ID_W-1:0]   id;
		logic [fqd_pkg::AMT_W-1:0]  amount;
		fqd_pkg::cmd_t              cmd;
		int               kind;
		int               len;
		int               idle_mode;
		int               gap;
		int               r;
		int               m;

		for (int k = 0; k < 8; k++)
			cmds_seen[k] = 0;
		for (int k = 0; k < POOL_SIZE; k++)
			pool[k] = fqd_pkg::ID_W'($urandom);

		// Empty queue corners, then a few entries to read, search and drop.
		queue_cmd(fqd_pkg::CMD_POP, 16'h0000, 8'd0, 0, 0);
		queue_cmd(fqd_pkg::CMD_READ_AT, 16'h0000, 8'd0, 0, 0);
		queue_cmd(fqd_pkg::CMD_READ_AT, 16'hFFFF, 8'd255, 0, 0);
		queue_cmd(fqd_pkg::CMD_DROP_N, 16'h0000, 8'd0, 0, 0);
		queue_cmd(fqd_pkg::CMD_CONTAINS, 16'h0000, 8'd0, 0, 0);
		queue_cmd(fqd_pkg::CMD_CLEAR, 16'h0000, 8'd0, 0, 0);
		queue_cmd(fqd_pkg::CMD_NOP, 16'hFFFF, 8'd255, 0, 0);
		queue_cmd(fqd_pkg::CMD_PUSH, 16'h0000, 8'd0, 0, 0);
		queue_cmd(fqd_pkg::CMD_PUSH, 16'hFFFF, 8'd255, 0, 0);
		queue_cmd(fqd_pkg::CMD_PUSH_UNIQUE, 16'hFFFF, 8'd0, 0, 0);
		queue_cmd(fqd_pkg::CMD_PUSH_UNIQUE, 16'h5A5A, 8'd0, 0, 0);
		queue_cmd(fqd_pkg::CMD_CONTAINS, 16'hFFFF, 8'd0, 0, 0);
		queue_cmd(fqd_pkg::CMD_CONTAINS, 16'h1234, 8'd0, 0, 0);
		queue_cmd(fqd_pkg::CMD_READ_AT, 16'h0000, 8'd0, 0, 0);
		queue_cmd(fqd_pkg::CMD_READ_AT, 16'h0000, 8'd1, 0, 0);
		queue_cmd(fqd_pkg::CMD_READ_AT, 16'h0000, 8'd3, 0, 0);
		queue_cmd(fqd_pkg::CMD_READ_AT, 16'h0000, 8'd4, 0, 0);
		queue_cmd(fqd_pkg::CMD_POP, 16'h0000, 8'd0, 0, 0);
		queue_cmd(fqd_pkg::CMD_DROP_N, 16'h0000, 8'd0, 0, 0);
		queue_cmd(fqd_pkg::CMD_NOP, 16'h0000, 8'd0, 0, 0);
		queue_cmd(fqd_pkg::CMD_CLEAR, 16'h0000, 8'd0, 0, 0);
		queue_cmd(fqd_pkg::CMD_PUSH, 16'hA5C3, 8'd0, 0, 0);
		queue_cmd(fqd_pkg::CMD_PUSH, 16'h3C5A, 8'd0, 0, 0);
		queue_cmd(fqd_pkg::CMD_DROP_N, 16'h0000, 8'd255, 0, 0);

		// Fill to the brim with random ids, then hit every refusal on a full queue.
		// The sender waits for all results before starting the fill.
		base = fqd_pkg::ID_W'($urandom);
		for (int k = 1; k <= QDEPTH; k++)
			queue_cmd(fqd_pkg::CMD_PUSH, base ^ fqd_pkg::ID_W'(k),
				fqd_pkg::AMT_W'($urandom), 0, k == 1);
		queue_cmd(fqd_pkg::CMD_PUSH, fqd_pkg::ID_W'($urandom), 8'd0, 0, 0);
		queue_cmd(fqd_pkg::CMD_PUSH_UNIQUE, base ^ 16'd7, 8'd0, 0, 0);
		queue_cmd(fqd_pkg::CMD_PUSH_UNIQUE, base, 8'd0, 0, 0);
		queue_cmd(fqd_pkg::CMD_READ_AT, 16'h0000, 8'd16, 0, 0);
		queue_cmd(fqd_pkg::CMD_READ_AT, 16'h0000, 8'd17, 0, 0);
		queue_cmd(fqd_pkg::CMD_DROP_N, 16'h0000, 8'd1, 0, 0);
		queue_cmd(fqd_pkg::CMD_PUSH, base, 8'd0, 0, 0);
		queue_cmd(fqd_pkg::CMD_DROP_N, 16'h0000, 8'd255, 3, 0);

		// Phases that lean toward filling, mixing or draining, each with its own idle style.
		while (cmds_to_send.size() < TOTAL_CMDS) begin
			kind = $urandom_range(0, 2);
			len = $urandom_range(15, 60);
			idle_mode = $urandom_range(0, 2);
			for (int j = 0; j < len; j++) begin
				r = $urandom_range(0, 99);
				cmd = fqd_pkg::CMD_NOP;
				for (int k = 6; k >= 0; k--)
					if (r < CUTS[kind][k])
						cmd = fqd_pkg::cmd_t'(k);
				id = ($urandom_range(0, 4) == 0) ? fqd_pkg::ID_W'($urandom)
					: pool[$urandom_range(0, POOL_SIZE - 1)];
				if (cmd == fqd_pkg::CMD_READ_AT || cmd == fqd_pkg::CMD_DROP_N) begin
					m = $urandom_range(0, 9);
					if (m < 6)
						amount = fqd_pkg::AMT_W'($urandom_range(0, 17));
					else if (m < 9)
						amount = fqd_pkg::AMT_W'($urandom_range(0, 3));
					else
						amount = fqd_pkg::AMT_W'($urandom_range(0, 255));
				end else
					amount = fqd_pkg::AMT_W'($urandom_range(0, 255));
				case (idle_mode)
					0: gap = 0;
					1: gap = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 18) : 0;
					default: gap = $urandom_range(0, 18);
				endcase
				queue_cmd(cmd, id, amount, gap, j == 0 && $urandom_range(0, 3) == 0);
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (cmds_to_send.size() > 0 || s_tvalid || replies_due.size() > 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (replies_due.size() > 0)
			$display("%0t: %0d results never arrived", $time, replies_due.size());
		$display("Checked %0d results; commands by code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d.",
			results_checked, cmds_seen[0], cmds_seen[1], cmds_seen[2], cmds_seen[3],
			cmds_seen[4], cmds_seen[5], cmds_seen[6], cmds_seen[7]);
		$display("Peak fill %0d; %0d full refusals, %0d duplicates, %0d range misses.",
			q_peak, full_refusals, dup_refusals, range_misses);
		if (mismatches == 0 && replies_due.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
